>>> design/rtmp_pkg.sv
// ----------------------------------------------------------------------------
// rtmp_pkg - shared types and constants of the chunk header parser
// Holds the per-stream context record, result kinds and parse phases.
// ----------------------------------------------------------------------------
`default_nettype none

package rtmp_pkg;

	localparam int NUM_STREAMS = 64;
	localparam int IDX_W       = $clog2(NUM_STREAMS);
	localparam logic [15:0] CHUNK_SIZE_RESET = 16'd128;
	localparam logic [23:0] TS_EXTENDED      = 24'hFFFFFF;

	typedef enum logic [1:0] {
		KIND_HDR  = 2'd0,
		KIND_DONE = 2'd1,
		KIND_PAY  = 2'd2,
		KIND_ERR  = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		PH_BASIC   = 4'd0,
		PH_EXT1    = 4'd1,
		PH_EXT2A   = 4'd2,
		PH_EXT2B   = 4'd3,
		PH_HDR0    = 4'd4,
		PH_HDR1    = 4'd5,
		PH_HDR2    = 4'd6,
		PH_EXTTS   = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_FIN3    = 4'd9
	} phase_t;

	// per chunk stream context
	typedef struct packed {
		logic [31:0] ts;
		logic [23:0] len;
		logic [7:0]  typ;
		logic [31:0] msid;
		logic [23:0] rcv;
	} ctx_t;

	// context memory access
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		ctx_t             wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

>>> design/rtmp_ctx_ram.sv
// ----------------------------------------------------------------------------
// rtmp_ctx_ram - per-stream context memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_ctx_ram (
	input  wire logic              clk,
	input  wire rtmp_pkg::ram_req_t req,
	output rtmp_pkg::ctx_t          rdata
);

	rtmp_pkg::ctx_t mem [rtmp_pkg::NUM_STREAMS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

`default_nettype wire

>>> design/rtmp_chunk_header_parser_unit.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_header_parser_unit - chunk stream header parser / demultiplexer
// Parses basic and message headers per byte, tracks stream context in memory.
// ----------------------------------------------------------------------------
// usage:
//  - s_* carries the stream one byte per beat; every byte gives exactly one
//    result beat on m_*: tuser is the kind (header byte, header complete,
//    payload byte, error), tlast flags the last byte of each message
//  - cfg_we/cfg_wdata load the chunk size (reset 128); write only when idle
//  - results are registered: each beat is held in the output register
//  - throughput: one byte per cycle while the receiver takes beats; a
//    type 3 header on a stream other than the one whose context is held in
//    the working registers stalls the input, since its context must first
//    come out of the context memory, whose read data is registered
//  - per-stream context lives in a 64 entry memory; a working copy of the
//    active stream is kept in registers, every update is written back, so
//    the memory is always current; valid bits are flops cleared by reset
//  - reset: parser returns to basic header start, all streams invalid,
//    no clearing pass is needed
//  - receiver stall: the output register holds the beat and s_tready drops
//    until it is taken; a new byte is accepted in the cycle it is taken
//  - after an error every byte answers with an error beat until reset
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_chunk_header_parser_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // in_byte
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// data_byte[7:0], chunk_stream[24:8], timestamp[56:25],
	// message_length[80:57], message_type[88:81], message_stream[120:89], zero
	output logic [127:0]      m_tdata,
	output logic [1:0]        m_tuser,   // kind
	output logic              m_tlast    // message_done
);

	localparam int IW = rtmp_pkg::IDX_W;

	// control state
	rtmp_pkg::phase_t          phase_q, ph_d;
	logic [15:0]               cnt_q, cnt_d;
	logic [55:0]               asm_q, asm_d;
	logic [1:0]                fmt_q, fmt_d;
	logic [16:0]               cur_q, cur_d;
	logic                      failed_q, fail_d;
	logic [rtmp_pkg::NUM_STREAMS-1:0] valid_q, valid_d;
	logic [IW-1:0]             own_q, own_d;
	logic                      own_v_q, own_v_d;
	logic                      pend_q, pend_d;
	logic [15:0]               chunk_q;

	// working copy of the active stream context
	rtmp_pkg::ctx_t            ctx_q, ctx_d, eff, rdata;
	rtmp_pkg::ram_req_t        ram_req;

	// output register
	logic                      out_v_q;
	logic [127:0]              out_data_q;
	logic [1:0]                out_kind_q;
	logic                      out_last_q;

	logic                      slot_free, acc, fin_go, do_step;
	logic                      emit, o_ctx, o_done, id_req, fin_req;
	rtmp_pkg::kind_t           o_kind;
	logic [7:0]                o_data;
	logic [16:0]               nid;
	logic [23:0]               remain, tsum24;
	logic [15:0]               cnt_min, k1;
	logic [31:0]               ts32;
	logic [IW-1:0]             nidx;

	assign slot_free = !out_v_q || m_tready;
	assign s_tready  = slot_free && (phase_q != rtmp_pkg::PH_FIN3);
	assign acc       = s_tvalid && s_tready;
	assign fin_go    = slot_free && (phase_q == rtmp_pkg::PH_FIN3);
	assign do_step   = acc || fin_go;
	assign eff       = pend_q ? rdata : ctx_q;
	assign nidx      = nid[IW-1:0];

	always_comb begin
		ph_d    = phase_q;
		cnt_d   = cnt_q;
		asm_d   = asm_q;
		fmt_d   = fmt_q;
		cur_d   = cur_q;
		fail_d  = failed_q;
		valid_d = valid_q;
		own_d   = own_q;
		own_v_d = own_v_q;
		pend_d  = 1'b0;
		ctx_d   = eff;
		emit    = 1'b0;
		o_kind  = rtmp_pkg::KIND_HDR;
		o_data  = 8'd0;
		o_ctx   = 1'b0;
		o_done  = 1'b0;
		id_req  = 1'b0;
		fin_req = 1'b0;
		nid     = 17'd0;
		k1      = cnt_q + 16'd1;
		ts32    = {asm_q[23:0], s_tdata};
		tsum24  = 24'd0;
		remain  = 24'd0;
		cnt_min = 16'd0;

		if (do_step) begin
			emit = 1'b1;
			if (failed_q) begin
				o_kind = rtmp_pkg::KIND_ERR;
			end else begin
				case (phase_q)
					rtmp_pkg::PH_EXT1: begin
						nid    = 17'd64 + {9'd0, s_tdata};
						id_req = 1'b1;
					end
					rtmp_pkg::PH_EXT2A: begin
						asm_d[7:0] = s_tdata;
						ph_d       = rtmp_pkg::PH_EXT2B;
					end
					rtmp_pkg::PH_EXT2B: begin
						nid        = 17'd64 + {9'd0, asm_q[7:0]} + {1'b0, s_tdata, 8'd0};
						asm_d[7:0] = 8'd0;
						id_req     = 1'b1;
					end
					rtmp_pkg::PH_HDR0, rtmp_pkg::PH_HDR1, rtmp_pkg::PH_HDR2: begin
						case (cnt_q)
							16'd0:   asm_d[23:16] = s_tdata;
							16'd1:   asm_d[15:8]  = s_tdata;
							16'd2:   asm_d[7:0]   = s_tdata;
							16'd3:   asm_d[47:40] = s_tdata;
							16'd4:   asm_d[39:32] = s_tdata;
							16'd5:   asm_d[31:24] = s_tdata;
							16'd6:   asm_d[55:48] = s_tdata;
							16'd7:   ctx_d.msid   = {24'd0, s_tdata};
							16'd8:   ctx_d.msid[15:8]  = s_tdata;
							16'd9:   ctx_d.msid[23:16] = s_tdata;
							16'd10:  ctx_d.msid[31:24] = s_tdata;
							default: ;
						endcase
						cnt_d = k1;
						// header bytes needed: 11, 7 or 3 by format
						if ((fmt_q == 2'd0 && k1 == 16'd11) ||
						    (fmt_q == 2'd1 && k1 == 16'd7) ||
						    (fmt_q == 2'd2 && k1 == 16'd3)) begin
							if (fmt_q == 2'd0) begin
								ctx_d.len      = asm_d[47:24];
								ctx_d.typ      = asm_d[55:48];
								ctx_d.rcv      = 24'd0;
								valid_d[own_q] = 1'b1;
								if (asm_d[23:0] == rtmp_pkg::TS_EXTENDED) begin
									ph_d  = rtmp_pkg::PH_EXTTS;
									cnt_d = 16'd0;
									asm_d = 56'd0;
								end else begin
									ctx_d.ts = {8'd0, asm_d[23:0]};
									fin_req  = 1'b1;
								end
							end else begin
								// 32 bit wrapping delta add
								ctx_d.ts = eff.ts + {8'd0, asm_d[23:0]};
								if (fmt_q == 2'd1) begin
									ctx_d.len = asm_d[47:24];
									ctx_d.typ = asm_d[55:48];
								end
								ctx_d.rcv = 24'd0;
								fin_req   = 1'b1;
							end
						end
					end
					rtmp_pkg::PH_EXTTS: begin
						asm_d = {24'd0, ts32};
						cnt_d = k1;
						if (k1 == 16'd4) begin
							ctx_d.ts = ts32;
							fin_req  = 1'b1;
						end
					end
					rtmp_pkg::PH_PAYLOAD: begin
						o_kind = rtmp_pkg::KIND_PAY;
						o_data = s_tdata;
						o_ctx  = 1'b1;
						tsum24 = eff.rcv + 24'd1;
						ctx_d.rcv = tsum24;
						if (tsum24 == eff.len) begin
							o_done    = 1'b1;
							ctx_d.rcv = 24'd0;
						end
						cnt_d = cnt_q - 16'd1;
						if (cnt_q == 16'd1) begin
							ph_d = rtmp_pkg::PH_BASIC;
						end
					end
					rtmp_pkg::PH_FIN3: begin
						fin_req = 1'b1;
					end
					default: begin
						fmt_d = s_tdata[7:6];
						asm_d = 56'd0;
						cnt_d = 16'd0;
						if (s_tdata[5:1] == 5'd0) begin
							cur_d = 17'd0;
							ph_d  = s_tdata[0] ? rtmp_pkg::PH_EXT2A : rtmp_pkg::PH_EXT1;
						end else begin
							nid    = {11'd0, s_tdata[5:0]};
							ph_d   = rtmp_pkg::PH_BASIC;
							id_req = 1'b1;
						end
					end
				endcase

				// chunk stream id complete
				if (id_req) begin
					cur_d = nid;
					if (nid >= 17'(rtmp_pkg::NUM_STREAMS) ||
					    (fmt_d != 2'd0 && !valid_q[nidx])) begin
						fail_d = 1'b1;
						o_kind = rtmp_pkg::KIND_ERR;
					end else begin
						own_d   = nidx;
						own_v_d = 1'b1;
						if (!(own_v_q && own_q == nidx)) begin
							pend_d = 1'b1;
						end
						cnt_d = 16'd0;
						if (fmt_d == 2'd3) begin
							if (own_v_q && own_q == nidx) begin
								fin_req = 1'b1;
							end else begin
								// context comes out of memory next cycle
								ph_d = rtmp_pkg::PH_FIN3;
								emit = 1'b0;
							end
						end else begin
							ph_d = rtmp_pkg::phase_t'({2'b01, fmt_d});
						end
					end
				end

				// header complete: fix payload count of this chunk
				if (fin_req) begin
					remain  = ctx_d.len - ctx_d.rcv;
					cnt_min = (remain > {8'd0, chunk_q}) ? chunk_q : remain[15:0];
					ph_d    = rtmp_pkg::PH_BASIC;
					cnt_d   = 16'd0;
					o_kind  = rtmp_pkg::KIND_DONE;
					o_ctx   = 1'b1;
					if (remain == 24'd0) begin
						ctx_d.rcv = 24'd0;
						o_done    = 1'b1;
					end else if (cnt_min != 16'd0) begin
						ph_d  = rtmp_pkg::PH_PAYLOAD;
						cnt_d = cnt_min;
					end
				end
			end
		end
	end

	// write back every update of the working copy
	always_comb begin
		ram_req.we    = do_step && own_v_q && !failed_q;
		ram_req.waddr = own_q;
		ram_req.wdata = ctx_d;
		ram_req.raddr = nidx;
	end

	rtmp_ctx_ram u_ctx_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= rtmp_pkg::PH_BASIC;
			cnt_q    <= 16'd0;
			asm_q    <= 56'd0;
			fmt_q    <= 2'd0;
			cur_q    <= 17'd0;
			failed_q <= 1'b0;
			valid_q  <= '0;
			own_q    <= '0;
			own_v_q  <= 1'b0;
			pend_q   <= 1'b0;
			chunk_q  <= rtmp_pkg::CHUNK_SIZE_RESET;
			out_v_q  <= 1'b0;
		end else begin
			phase_q  <= ph_d;
			cnt_q    <= cnt_d;
			asm_q    <= asm_d;
			fmt_q    <= fmt_d;
			cur_q    <= cur_d;
			failed_q <= fail_d;
			valid_q  <= valid_d;
			own_q    <= own_d;
			own_v_q  <= own_v_d;
			pend_q   <= pend_d;
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		ctx_q <= ctx_d;
		if (emit) begin
			out_kind_q <= o_kind;
			out_last_q <= o_done;
			out_data_q <= {7'd0,
				o_ctx ? ctx_d.msid : 32'd0,
				o_ctx ? ctx_d.typ  : 8'd0,
				o_ctx ? ctx_d.len  : 24'd0,
				o_ctx ? ctx_d.ts   : 32'd0,
				(o_kind == rtmp_pkg::KIND_ERR) ? 17'd0 : cur_d,
				o_data};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q |=> failed_q)
		else $error("error state left without reset");

	a_err_means_failed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == rtmp_pkg::KIND_ERR |-> failed_q)
		else $error("error beat without error state");

	a_fin3_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == rtmp_pkg::PH_FIN3 |-> !s_tready && !failed_q)
		else $error("byte taken while type 3 context loads");

	a_fin3_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(phase_q == rtmp_pkg::PH_FIN3) |-> pend_q)
		else $error("type 3 finish without context read");

	a_wb_owner: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.we |-> own_v_q && valid_q[own_q] || phase_q != rtmp_pkg::PH_PAYLOAD)
		else $error("payload update for stream without context");

endmodule

`default_nettype wire
